[sv/cobsrx_pkg.sv]
// ----------------------------------------------------------------------------
// cobsrx_pkg
// Shared constants, types and the CRC-8 step for the COBS packet receiver.
// ----------------------------------------------------------------------------
package cobsrx_pkg;

    localparam int MAX_DECODED_DEF = 64;
    localparam int BYTE_W          = 8;

    localparam logic [BYTE_W-1:0] CRC_POLY        = 8'h07;
    localparam logic [BYTE_W-1:0] FULL_BLOCK_CODE = 8'hFF;
    localparam logic [BYTE_W-1:0] DELIM_BYTE      = 8'h00;

    typedef enum logic [1:0] {
        ST_RECV,
        ST_READ,
        ST_SEND
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic ingest;   // non-zero byte transfer
        logic delim;    // delimiter transfer
        logic rd_en;    // read next payload byte from store
        logic rd_adv;   // result transfer, move to next entry
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic byte_zero;
        logic frame_ok;
        logic frame_empty;
        logic rd_last;
    } sts_t;

    // CRC-8, MSB first, no final xor
    function automatic logic [BYTE_W-1:0] crc_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1])
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[sv/cobsrx_ctrl.sv]
// ----------------------------------------------------------------------------
// cobsrx_ctrl
// Controller: takes bytes while receiving, walks the store to drain a frame.
// ----------------------------------------------------------------------------
module cobsrx_ctrl
    import cobsrx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_RECV;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_RECV:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (sts.byte_zero) begin
                        cmd.delim = 1'b1;
                        if (sts.frame_ok)
                            state_next = sts.frame_empty ? ST_SEND : ST_READ;
                    end else begin
                        cmd.ingest = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready) begin
                    if (sts.rd_last) begin
                        state_next = ST_RECV;
                    end else begin
                        cmd.rd_adv = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

endmodule

[sv/cobsrx_dp.sv]
// ----------------------------------------------------------------------------
// cobsrx_dp
// Datapath: COBS decode, CRC-8, decoded byte store and result register.
// ----------------------------------------------------------------------------
module cobsrx_dp
    import cobsrx_pkg::*;
#(
    parameter int MAX_DECODED = MAX_DECODED_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BYTE_W-1:0] rx_byte,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic [BYTE_W-1:0] message_id,
    output logic [BYTE_W-1:0] payload_byte,
    output logic              payload_valid
);

    localparam int AW = $clog2(MAX_DECODED);
    localparam int CW = $clog2(MAX_DECODED + 1);

    logic [BYTE_W-1:0] mem [MAX_DECODED];

    logic [CW-1:0]     cnt_reg,  cnt_next;
    logic [BYTE_W-1:0] rem_reg,  rem_next;
    logic              zp_reg,   zp_next;
    logic [BYTE_W-1:0] crc_reg,  crc_next;
    logic              err_reg,  err_next;

    logic [BYTE_W-1:0] crc_byte_reg;
    logic [BYTE_W-1:0] id_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [CW-1:0]     end_reg;
    logic [CW-1:0]     rd_ptr_reg;
    logic              pv_reg;

    logic              st_en;
    logic [BYTE_W-1:0] st_val;
    logic              wr_en;
    logic              full;

    assign full  = (cnt_reg >= CW'(MAX_DECODED));
    assign wr_en = st_en && !full;

    always_comb
    begin
        st_en  = 1'b0;
        st_val = rx_byte;
        if (cmd.ingest) begin
            if (rem_reg == '0) begin
                st_en  = zp_reg;
                st_val = '0;
            end else begin
                st_en  = 1'b1;
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        zp_next  = zp_reg;
        crc_next = crc_reg;
        err_next = err_reg;
        if (cmd.delim) begin
            cnt_next = '0;
            rem_next = '0;
            zp_next  = 1'b0;
            crc_next = '0;
            err_next = 1'b0;
        end else if (cmd.ingest) begin
            if (rem_reg == '0) begin
                rem_next = rx_byte - BYTE_W'(1);
                zp_next  = (rx_byte != FULL_BLOCK_CODE);
            end else begin
                rem_next = rem_reg - BYTE_W'(1);
            end
            if (st_en) begin
                if (full) begin
                    err_next = 1'b1;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                    if (cnt_reg != '0)
                        crc_next = crc_update(crc_reg, st_val);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
            rem_reg <= '0;
            zp_reg  <= 1'b0;
            crc_reg <= '0;
            err_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            rem_reg <= rem_next;
            zp_reg  <= zp_next;
            crc_reg <= crc_next;
            err_reg <= err_next;
        end
    end

    // store and read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[cnt_reg[AW-1:0]] <= st_val;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_ptr_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && cnt_reg == CW'(0))
            crc_byte_reg <= st_val;
        if (wr_en && cnt_reg == CW'(1))
            id_reg <= st_val;
        if (cmd.delim) begin
            end_reg    <= cnt_reg;
            rd_ptr_reg <= CW'(2);
            pv_reg     <= (cnt_reg != CW'(2));
        end else if (cmd.rd_adv) begin
            rd_ptr_reg <= rd_ptr_reg + CW'(1);
        end
    end

    assign sts.byte_zero   = (rx_byte == DELIM_BYTE);
    assign sts.frame_ok    = !err_reg && (rem_reg == '0) && (cnt_reg >= CW'(2))
                             && (crc_byte_reg == crc_reg);
    assign sts.frame_empty = (cnt_reg == CW'(2));
    assign sts.rd_last     = !pv_reg || ((rd_ptr_reg + CW'(1)) == end_reg);

    assign message_id    = id_reg;
    assign payload_byte  = pv_reg ? rd_data_reg : '0;
    assign payload_valid = pv_reg;

endmodule

[sv/cobs_crc8_packet_receiver_unit.sv]
// ----------------------------------------------------------------------------
// cobs_crc8_packet_receiver_unit
// COBS deframer with CRC-8 check; emits id and payload of good frames.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   
//  s_axis    in   tdata[7:0] rx_byte                        
//  m_axis    out  tdata[7:0] message_id, [15:8] payload_byte,
//                 tuser payload_valid, tlast last            
//
//  Bytes are taken one per cycle while receiving; decode and CRC run per byte.
//  A good frame's delimiter starts a drain: per result a store read, then a
//  result transfer (held by any output stall); an empty payload needs only
//  the transfer. Input is held off during the drain only; bad frames skip it.
//  Reset is asynchronous; the byte store needs no clearing pass.
// ----------------------------------------------------------------------------
module cobs_crc8_packet_receiver_unit
    import cobsrx_pkg::*;
#(
    parameter int MAX_DECODED = MAX_DECODED_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] message_id, [15:8] payload_byte
    output logic        m_axis_tuser,   // payload_valid
    output logic        m_axis_tlast
);

    cmd_t              cmd;
    sts_t              sts;
    logic [BYTE_W-1:0] message_id;
    logic [BYTE_W-1:0] payload_byte;

    cobsrx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cobsrx_dp #(
        .MAX_DECODED (MAX_DECODED)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_byte       (s_axis_tdata),
        .cmd           (cmd),
        .sts           (sts),
        .message_id    (message_id),
        .payload_byte  (payload_byte),
        .payload_valid (m_axis_tuser)
    );

    assign m_axis_tdata = {payload_byte, message_id};
    assign m_axis_tlast = sts.rd_last;

endmodule

[sim/tb_cobs_crc8_packet_receiver_unit.sv]
// ----------------------------------------------------------------------------
// tb_cobs_crc8_packet_receiver_unit
// Self-checking bench for the COBS/CRC-8 packet receiver. Encoded frames,
// corrupted frames and line noise are streamed in byte by byte. A built-in
// decoder model predicts every result transfer, and a scoreboard compares
// each field. Idle and stall rates on both sides change from phase to phase.
// ----------------------------------------------------------------------------
module tb_cobs_crc8_packet_receiver_unit;

    import cobsrx_pkg::*;

    localparam int DEPTH       = MAX_DECODED_DEF;
    localparam int DEPTH_AW    = $clog2(DEPTH);
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        bit         drain_wait;
        logic [7:0] rx;
    } stim_t;

    typedef struct packed {
        logic [7:0] msg_id;
        logic [7:0] pl_byte;
        logic       pl_valid;
        logic       last_flag;
    } pkt_result_t;

    typedef enum int {
        PK_GOOD,
        PK_BAD_CRC,
        PK_CUT,
        PK_OVERFLOW,
        PK_NOISE
    } pkt_kind_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;             // [7:0] message_id, [15:8] payload_byte
    logic        m_axis_tuser;             // payload_valid
    logic        m_axis_tlast;

    stim_t       rx_bytes_q[$];
    pkt_result_t pending_results[$];
    logic [7:0]  raw_body[$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_cycles  = 0;
    int idle_cycles  = 0;
    logic results_drained = 1'b1;

    int mismatches      = 0;
    int results_checked = 0;
    int bytes_taken     = 0;
    int frames_seen     = 0;
    int frames_ok       = 0;

    // decoder model state
    logic [7:0] dec_store [DEPTH];
    logic [6:0] dec_count = '0;
    logic [7:0] blk_left  = '0;
    logic       zero_pend = 1'b0;
    logic [7:0] frame_crc = '0;
    logic       frame_bad = 1'b0;

    cobs_crc8_packet_receiver_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] din);
        logic [7:0] r;
        r = acc ^ din;
        for (int k = 0; k < 8; k++)
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        return r;
    endfunction

    task automatic store_decoded(input logic [7:0] b);
        if (dec_count >= DEPTH)
        begin
            frame_bad = 1'b1;
        end
        else
        begin
            dec_store[dec_count[DEPTH_AW-1:0]] = b;
            if (dec_count != 0)
                frame_crc = crc8_next(frame_crc, b);
            dec_count = dec_count + 1'b1;
        end
    endtask

    // predicts the result transfers caused by one received byte
    task automatic decode_rx_byte(input logic [7:0] b);
        pkt_result_t r;
        if (b != DELIM_BYTE)
        begin
            if (blk_left == 0)
            begin
                if (zero_pend)
                    store_decoded(8'h00);
                blk_left  = b - 8'd1;
                zero_pend = (b != FULL_BLOCK_CODE);
            end
            else
            begin
                store_decoded(b);
                blk_left = blk_left - 8'd1;
            end
        end
        else
        begin
            frames_seen++;
            if (!frame_bad && blk_left == 0 && dec_count >= 2 && dec_store[0] == frame_crc)
            begin
                frames_ok++;
                r.msg_id = dec_store[1];
                if (dec_count == 2)
                begin
                    r.pl_byte   = 8'h00;
                    r.pl_valid  = 1'b0;
                    r.last_flag = 1'b1;
                    pending_results.push_back(r);
                end
                else
                begin
                    for (int i = 2; i < dec_count; i++)
                    begin
                        r.pl_byte   = dec_store[i[DEPTH_AW-1:0]];
                        r.pl_valid  = 1'b1;
                        r.last_flag = (i + 1 == dec_count);
                        pending_results.push_back(r);
                    end
                end
            end
            dec_count = '0;
            blk_left  = '0;
            zero_pend = 1'b0;
            frame_crc = '0;
            frame_bad = 1'b0;
        end
    endtask

    task automatic push_rx(input logic [7:0] b);
        rx_bytes_q.push_back('{1'b0, b});
    endtask

    task automatic push_drain_wait();
        rx_bytes_q.push_back('{1'b1, 8'h00});
    endtask

    // id and payload into raw_body
    task automatic build_body(input logic [7:0] id, input int plen, input int zero_pct);
        raw_body.delete();
        raw_body.push_back(id);
        repeat (plen)
            raw_body.push_back(($urandom_range(99) < zero_pct) ? 8'h00 : 8'($urandom_range(255, 1)));
    endtask

    // prefixes the CRC of raw_body, COBS-encodes it and queues it with a delimiter
    task automatic queue_packet(input bit bad_crc, input bit cut_short);
        logic [7:0] crc;
        logic [7:0] enc[$];
        int code_at;
        int code;
        int k;
        crc = 8'h00;
        foreach (raw_body[i])
            crc = crc8_next(crc, raw_body[i]);
        if (bad_crc)
            crc = crc ^ 8'($urandom_range(255, 1));
        raw_body.push_front(crc);
        code_at = 0;
        code    = 1;
        enc.push_back(8'h00);
        foreach (raw_body[i])
        begin
            if (raw_body[i] == 8'h00)
            begin
                enc[code_at] = 8'(code);
                code_at = enc.size();
                enc.push_back(8'h00);
                code = 1;
            end
            else
            begin
                enc.push_back(raw_body[i]);
                code++;
                if (code == 255)
                begin
                    enc[code_at] = FULL_BLOCK_CODE;
                    code_at = enc.size();
                    enc.push_back(8'h00);
                    code = 1;
                end
            end
        end
        enc[code_at] = 8'(code);
        if (cut_short)
        begin
            // block opened but delimiter arrives before its data is complete
            k = $urandom_range(3);
            enc.push_back(8'(k + 2));
            repeat (k)
                enc.push_back(8'($urandom_range(255, 1)));
        end
        foreach (enc[i])
            push_rx(enc[i]);
        push_rx(DELIM_BYTE);
    endtask

    task automatic fill_random(input int budget);
        int start;
        int r;
        int n;
        pkt_kind_t kind;
        start = rx_bytes_q.size();
        while (rx_bytes_q.size() - start < budget)
        begin
            r = $urandom_range(99);
            kind = (r < 68) ? PK_GOOD : (r < 76) ? PK_BAD_CRC : (r < 84) ? PK_CUT :
                   (r < 90) ? PK_OVERFLOW : PK_NOISE;
            case (kind)
                PK_GOOD:
                begin
                    n = ($urandom_range(11) == 0) ? $urandom_range(62, 9) : $urandom_range(8);
                    build_body(8'($urandom_range(255)), n, $urandom_range(50));
                    queue_packet(1'b0, 1'b0);
                end
                PK_BAD_CRC:
                begin
                    build_body(8'($urandom_range(255)), $urandom_range(6), $urandom_range(50));
                    queue_packet(1'b1, 1'b0);
                end
                PK_CUT:
                begin
                    build_body(8'($urandom_range(255)), $urandom_range(6), $urandom_range(50));
                    queue_packet(1'b0, 1'b1);
                end
                PK_OVERFLOW:
                begin
                    build_body(8'($urandom_range(255)), $urandom_range(70, 63), $urandom_range(30));
                    queue_packet(1'b0, 1'b0);
                end
                default:
                begin
                    n = $urandom_range(6, 1);
                    repeat (n)
                        push_rx(8'($urandom_range(255)));
                    push_rx(DELIM_BYTE);
                end
            endcase
            if ($urandom_range(9) == 0)
                push_drain_wait();
        end
    endtask

    task automatic drain_all();
        while (rx_bytes_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
            @(posedge clk);
    endtask

    // byte source
    always @(posedge clk or negedge rst_n)
    begin : rx_source
        stim_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            hold_cycles   <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (rx_bytes_q.size() > 0 && rx_bytes_q[0].drain_wait)
            begin
                s_axis_tvalid <= 1'b0;
                if (hold_cycles >= 1 && results_drained)
                begin
                    nxt = rx_bytes_q.pop_front();
                    hold_cycles <= 0;
                end
                else
                begin
                    hold_cycles <= hold_cycles + 1;
                end
            end
            else if (rx_bytes_q.size() > 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                nxt = rx_bytes_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.rx;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result sink backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // scoreboard: check result transfers, then predict from byte transfers
    always @(posedge clk)
    begin : scoreboard
        pkt_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result transfer: tdata %04h tuser %b tlast %b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_checked = results_checked + 1;
                    if (m_axis_tdata[7:0] !== want.msg_id)
                    begin
                        $error("message_id: expected %02h, actual %02h",
                               want.msg_id, m_axis_tdata[7:0]);
                        mismatches = mismatches + 1;
                    end
                    if (m_axis_tdata[15:8] !== want.pl_byte)
                    begin
                        $error("payload_byte: expected %02h, actual %02h",
                               want.pl_byte, m_axis_tdata[15:8]);
                        mismatches = mismatches + 1;
                    end
                    if (m_axis_tuser !== want.pl_valid)
                    begin
                        $error("payload_valid: expected %b, actual %b",
                               want.pl_valid, m_axis_tuser);
                        mismatches = mismatches + 1;
                    end
                    if (m_axis_tlast !== want.last_flag)
                    begin
                        $error("last: expected %b, actual %b", want.last_flag, m_axis_tlast);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                bytes_taken = bytes_taken + 1;
                decode_rx_byte(s_axis_tdata);
            end
            results_drained <= (pending_results.size() == 0);
        end
    end

    // watchdog: cycles with work pending but no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (rx_bytes_q.size() == 0 && !s_axis_tvalid && pending_results.size() == 0))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed frames, no idling
        @(negedge clk);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        push_rx(DELIM_BYTE);                        // empty frame
        push_rx(8'h02);                             // single decoded byte
        push_rx(8'h5A);
        push_rx(DELIM_BYTE);
        build_body(8'h00, 0, 0);                    // empty payload, id and crc zero
        queue_packet(1'b0, 1'b0);
        raw_body.delete();                          // field extremes
        raw_body.push_back(8'hFF);
        raw_body.push_back(8'h00);
        raw_body.push_back(8'hFF);
        queue_packet(1'b0, 1'b0);
        push_drain_wait();
        raw_body.delete();                          // back-to-back zeros
        raw_body.push_back(8'h7E);
        raw_body.push_back(8'h00);
        raw_body.push_back(8'h00);
        queue_packet(1'b0, 1'b0);
        build_body(8'($urandom_range(255)), 2, 20); // crc mismatch
        queue_packet(1'b1, 1'b0);
        build_body(8'($urandom_range(255)), 2, 0);  // truncated block
        queue_packet(1'b0, 1'b1);
        push_rx(FULL_BLOCK_CODE);                   // full-size code, cut short
        push_rx(8'h11);
        push_rx(8'h22);
        push_rx(DELIM_BYTE);
        drain_all();

        // random, no idling; starts with a full store and an overflow
        @(negedge clk);
        build_body(8'($urandom_range(255)), 62, 10);
        queue_packet(1'b0, 1'b0);
        build_body(8'($urandom_range(255)), 63, 10);
        queue_packet(1'b0, 1'b0);
        fill_random(20);
        drain_all();

        @(negedge clk);
        tx_idle_pct  = 78;
        rx_stall_pct = 0;
        fill_random(20);
        drain_all();

        @(negedge clk);
        tx_idle_pct  = 0;
        rx_stall_pct = 78;
        fill_random(20);
        drain_all();

        // both sides idle; long run of non-zero bytes uses full-size blocks
        @(negedge clk);
        tx_idle_pct  = 30;
        rx_stall_pct = 30;
        build_body(8'($urandom_range(255, 1)), 253, 0);
        queue_packet(1'b0, 1'b0);
        fill_random(20);
        drain_all();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d bytes in %0d frames (good, bad crc, truncated, overflow, noise).",
                 bytes_taken, frames_seen);
        $display("%0d frames passed the crc check; %0d result transfers compared.",
                 frames_ok, results_checked);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
sv/cobsrx_pkg.sv
sv/cobsrx_ctrl.sv
sv/cobsrx_dp.sv
sv/cobs_crc8_packet_receiver_unit.sv
sim/tb_cobs_crc8_packet_receiver_unit.sv
